// ----- design/llr_pkg.sv -----
// Shared types, constants and codes of the looping linear resampler.
// No dependencies; llr_if, llr_regs, llr_dp, llr_ctrl and the top import it.
package llr_pkg;

  localparam int SAMPLE_DEPTH_DEF = 65536;
  localparam int SAMPLE_BITS      = 16;
  localparam int FRAC_BITS        = 16;
  localparam int WEIGHT_BITS      = 16;
  localparam int POS_W            = 34;
  localparam int ADDR_IN_W        = 16;
  localparam int RATIO_W          = 24;
  localparam int LEN_IN_W         = 17;
  localparam int CFG_ADDR_W       = 5;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_SEEK = 2'd1;
  localparam logic [1:0] ACT_PULL = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic [2:0] REG_RATIO  = 3'd0;
  localparam logic [2:0] REG_LOOPON = 3'd1;
  localparam logic [2:0] REG_LBEGIN = 3'd2;
  localparam logic [2:0] REG_LFIN   = 3'd3;
  localparam logic [2:0] REG_FADE   = 3'd4;
  localparam logic [2:0] REG_SRCLEN = 3'd5;

  typedef struct packed {
    logic signed [RATIO_W-1:0] rate_ratio;
    logic                      loop_on;
    logic [31:0]               loop_begin;
    logic [31:0]               loop_finish;
    logic [31:0]               fade_length;
    logic [LEN_IN_W-1:0]       source_length;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic wrap;
    logic check;
    logic rd_sel;
    logic cap_a;
    logic mul;
    logic lerp;
    logic pass;
    logic div_step;
    logic load_wp;
    logic mixm;
    logic mixa;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic oob;
    logic fade_hit;
    logic div_last;
    logic wp_ok;
  } status_t;

endpackage

// ----- design/llr_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
// Depends on llr_pkg for field widths.
interface llr_in_if import llr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [ADDR_IN_W-1:0]          sample_address;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic [31:0]                   seek_position;

  modport source (output valid, action, sample_address, sample_left, sample_right,
                  seek_position, input ready);
  modport sink (input valid, action, sample_address, sample_left, sample_right,
                seek_position, output ready);
endinterface

interface llr_out_if import llr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          frame_valid;
  logic                          track_ended;
  logic signed [POS_W-1:0]       current_position;

  modport source (output valid, out_left, out_right, frame_valid, track_ended,
                  current_position, input ready);
  modport sink (input valid, out_left, out_right, frame_valid, track_ended,
                current_position, output ready);
endinterface

// ----- design/llr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/llr_regs.sv -----
// APB configuration registers of the resampler.
// Depends on llr_pkg for cfg_t and register indexes.
module llr_regs import llr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_ratio    <= RATIO_W'(65536);
      cfg_r.loop_on       <= 1'b0;
      cfg_r.loop_begin    <= '0;
      cfg_r.loop_finish   <= '0;
      cfg_r.fade_length   <= '0;
      cfg_r.source_length <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_RATIO:  cfg_r.rate_ratio    <= $signed(pwdata[RATIO_W-1:0]);
        REG_LOOPON: cfg_r.loop_on       <= pwdata[0];
        REG_LBEGIN: cfg_r.loop_begin    <= pwdata;
        REG_LFIN:   cfg_r.loop_finish   <= pwdata;
        REG_FADE:   cfg_r.fade_length   <= pwdata;
        REG_SRCLEN: cfg_r.source_length <= pwdata[LEN_IN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RATIO:  prdata = 32'(unsigned'(cfg_r.rate_ratio));
      REG_LOOPON: prdata = 32'(cfg_r.loop_on);
      REG_LBEGIN: prdata = cfg_r.loop_begin;
      REG_LFIN:   prdata = cfg_r.loop_finish;
      REG_FADE:   prdata = cfg_r.fade_length;
      REG_SRCLEN: prdata = 32'(cfg_r.source_length);
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- design/llr_dp.sv -----
// Datapath: position arithmetic, sample memory, interpolation, seam divider and mix.
// Depends on llr_pkg and llr_ram; driven by llr_ctrl commands.
module llr_dp import llr_pkg::*; #(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  cmd_t                          cmd,
  output status_t                       st,
  input  logic [1:0]                    action,
  input  logic [ADDR_IN_W-1:0]          sample_address,
  input  logic signed [SAMPLE_BITS-1:0] sample_left,
  input  logic signed [SAMPLE_BITS-1:0] sample_right,
  input  logic [31:0]                   seek_position,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          frame_valid,
  output logic                          track_ended,
  output logic signed [POS_W-1:0]       current_position
);

  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int LEN_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int LIM_W  = LEN_W + FRAC_BITS;
  localparam int WK_W   = (LIM_W + 2 > 36) ? LIM_W + 2 : 36;
  localparam int PW     = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int MW     = SAMPLE_BITS + WEIGHT_BITS + 2;
  localparam int CNT_W  = $clog2(WEIGHT_BITS);
  localparam logic signed [PW-1:0]  HALF_F = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [MW:0]    HALF_W = (MW + 1)'(1) << (WEIGHT_BITS - 1);
  localparam logic [WEIGHT_BITS:0]  ONE_W  = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;

  logic [LEN_W-1:0]               len;
  logic signed [WK_W-1:0]         lim, ratio_s, lb, lf, fd, pos_in, seam_gap, wp;
  logic                           looping;
  logic signed [WK_W-1:0]         pos_r, ipos_r;
  logic signed [POS_W-1:0]        rpos_r;
  logic [31:0]                    gap_r, rem_r;
  logic [32:0]                    rem2;
  logic [CNT_W-1:0]               cnt_r;
  logic [WEIGHT_BITS-1:0]         t_r;
  logic [WEIGHT_BITS:0]           u;
  logic                           fade_hit_r;
  logic [ADDR_W-1:0]              i0, i1, raddr, waddr;
  logic [FRAC_BITS-1:0]           fr;
  logic                           in_range;
  logic [2*SAMPLE_BITS-1:0]       ram_q;
  logic signed [SAMPLE_BITS-1:0]  a_l_r, a_r_r, b_l, b_r, s_l, s_r;
  logic signed [SAMPLE_BITS:0]    d_l, d_r;
  logic signed [PW-1:0]           prod_l_r, prod_r_r;
  logic signed [SAMPLE_BITS-1:0]  res_l_r, res_r_r, ws_l_r, ws_r_r;
  logic                           res_valid_r, res_end_r;
  logic signed [MW-1:0]           mt_l_r, mt_r_r, mu_l_r, mu_r_r;
  logic signed [MW:0]             mix_l, mix_r;

  assign len = (32'(cfg.source_length) > 32'(SAMPLE_DEPTH)) ? LEN_W'(SAMPLE_DEPTH)
                                                            : LEN_W'(cfg.source_length);
  assign lim      = $signed(WK_W'({len, {FRAC_BITS{1'b0}}}));
  assign ratio_s  = WK_W'(cfg.rate_ratio);
  assign lb       = $signed(WK_W'(cfg.loop_begin));
  assign lf       = $signed(WK_W'(cfg.loop_finish));
  assign fd       = $signed(WK_W'(cfg.fade_length));
  assign looping  = cfg.loop_on && !cfg.rate_ratio[RATIO_W-1] && (cfg.rate_ratio != '0);
  assign pos_in   = WK_W'(rpos_r);
  assign seam_gap = lf - pos_r;
  assign wp       = lb + fd - $signed(WK_W'(gap_r));

  assign st.oob      = (pos_r < 0) || (pos_r >= lim);
  assign st.fade_hit = fade_hit_r;
  assign st.div_last = (cnt_r == CNT_W'(WEIGHT_BITS - 1));
  assign st.wp_ok    = (wp < lim);

  // Frame index pair and fraction of the interpolation point
  assign i0    = ipos_r[FRAC_BITS +: ADDR_W];
  assign fr    = ipos_r[FRAC_BITS-1:0];
  assign i1    = (32'(i0) + 32'd1 < 32'(len)) ? i0 + ADDR_W'(1) : i0;
  assign raddr = cmd.rd_sel ? i1 : i0;

  assign in_range = 32'(sample_address) < 32'(SAMPLE_DEPTH);
  assign waddr    = ADDR_W'(sample_address);

  llr_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept && (action == ACT_LOAD) && in_range),
    .waddr (waddr),
    .wdata ({sample_left, sample_right}),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign b_l = $signed(ram_q[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign b_r = $signed(ram_q[SAMPLE_BITS-1:0]);
  assign d_l = (SAMPLE_BITS + 1)'(b_l) - (SAMPLE_BITS + 1)'(a_l_r);
  assign d_r = (SAMPLE_BITS + 1)'(b_r) - (SAMPLE_BITS + 1)'(a_r_r);
  assign s_l = SAMPLE_BITS'(PW'(a_l_r) + ((prod_l_r + HALF_F) >>> FRAC_BITS));
  assign s_r = SAMPLE_BITS'(PW'(a_r_r) + ((prod_r_r + HALF_F) >>> FRAC_BITS));

  assign rem2  = {rem_r, 1'b0};
  assign u     = ONE_W - (WEIGHT_BITS + 1)'(t_r);
  assign mix_l = ((MW + 1)'(mt_l_r) + (MW + 1)'(mu_l_r) + HALF_W) >>> WEIGHT_BITS;
  assign mix_r = ((MW + 1)'(mt_r_r) + (MW + 1)'(mu_r_r) + HALF_W) >>> WEIGHT_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpos_r <= '0;
    end else if (cmd.accept && (action == ACT_SEEK)) begin
      rpos_r <= $signed(POS_W'(seek_position));
    end else if (cmd.check) begin
      if (st.oob) begin
        rpos_r <= (pos_r < 0) ? '0 : POS_W'(lim);
      end else begin
        rpos_r <= POS_W'(pos_r + ratio_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_l_r     <= '0;
      res_r_r     <= '0;
      res_valid_r <= 1'b0;
      res_end_r   <= 1'b0;
    end
    if (cmd.wrap) begin
      if (looping && (pos_in >= lf)) begin
        pos_r <= lb + (pos_in - lf);
      end else begin
        pos_r <= pos_in;
      end
    end
    if (cmd.check) begin
      ipos_r     <= pos_r;
      gap_r      <= 32'(seam_gap);
      rem_r      <= 32'(seam_gap);
      cnt_r      <= '0;
      fade_hit_r <= looping && (seam_gap > 0) && (seam_gap < fd);
      if (st.oob) begin
        res_end_r <= 1'b1;
      end
    end
    if (cmd.cap_a) begin
      a_l_r <= b_l;
      a_r_r <= b_r;
    end
    if (cmd.mul) begin
      prod_l_r <= d_l * $signed({1'b0, fr});
      prod_r_r <= d_r * $signed({1'b0, fr});
    end
    if (cmd.lerp) begin
      if (!cmd.pass) begin
        res_l_r     <= s_l;
        res_r_r     <= s_r;
        res_valid_r <= 1'b1;
      end else begin
        ws_l_r <= s_l;
        ws_r_r <= s_r;
      end
    end
    // Restoring division: one quotient bit per step
    if (cmd.div_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (rem2 >= {1'b0, cfg.fade_length}) begin
        rem_r <= 32'(rem2 - {1'b0, cfg.fade_length});
        t_r   <= {t_r[WEIGHT_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem2[31:0];
        t_r   <= {t_r[WEIGHT_BITS-2:0], 1'b0};
      end
    end
    if (cmd.load_wp) begin
      ipos_r <= wp;
    end
    if (cmd.mixm) begin
      mt_l_r <= res_l_r * $signed({1'b0, t_r});
      mt_r_r <= res_r_r * $signed({1'b0, t_r});
      mu_l_r <= ws_l_r * $signed({1'b0, u});
      mu_r_r <= ws_r_r * $signed({1'b0, u});
    end
    if (cmd.mixa) begin
      res_l_r <= SAMPLE_BITS'(mix_l);
      res_r_r <= SAMPLE_BITS'(mix_r);
    end
    if (cmd.emit) begin
      out_left         <= res_l_r;
      out_right        <= res_r_r;
      frame_valid      <= res_valid_r;
      track_ended      <= res_end_r;
      current_position <= rpos_r;
    end
  end

endmodule

// ----- design/llr_ctrl.sv -----
// Controller state machine that sequences loads, seeks and pulls.
// Depends on llr_pkg; drives llr_dp through cmd_t, reads status_t.
module llr_ctrl import llr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    st,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_RD0   = 4'd3;
  localparam logic [3:0] S_RD1   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_LERP  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_MIXM  = 4'd8;
  localparam logic [3:0] S_MIXA  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    cmd           = '0;
    cmd.pass      = pass_r;
    cmd.accept    = accept;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_action == ACT_PULL) ? S_WRAP : S_OUT;
        end
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        pass_nxt  = 1'b0;
        state_nxt = st.oob ? S_OUT : S_RD0;
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd_sel = 1'b1;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LERP;
      end
      S_LERP: begin
        cmd.lerp = 1'b1;
        if (pass_r) begin
          state_nxt = S_MIXM;
        end else begin
          state_nxt = st.fade_hit ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          if (st.wp_ok) begin
            cmd.load_wp = 1'b1;
            pass_nxt    = 1'b1;
            state_nxt   = S_RD0;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MIXM: begin
        cmd.mixm  = 1'b1;
        state_nxt = S_MIXA;
      end
      S_MIXA: begin
        cmd.mixa  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_pull_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_PULL) |=> state_r == S_WRAP)
    else $error("pull did not start with the loop wrap");

  a_oob_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) && st.oob |=> state_r == S_OUT)
    else $error("out-of-range pull went on to fetch samples");

  a_mix_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIXM) |-> pass_r)
    else $error("mix without wrapped-signal fetch");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.emit)
    else $error("result overwritten before transfer");

endmodule

// ----- design/looping_linear_resampler.sv -----
// Looping linear resampler: a stereo sample player with its own sample memory.
// Each item is a load, a seek, a pull or a no-op; every item returns one result.
// A pull ends the track when its position is out of range; in the crossfade seam
// before the loop end it also divides for the seam weight and, unless the wrapped
// point falls past the source, interpolates that point too and mixes the two: the
// samples of each interpolation point come through the single read port of the
// sample memory one frame per cycle, and the seam weight comes from a radix-2
// divider that resolves one of its 16 bits per cycle. A new item is taken once the
// previous result has moved into the output register; there is no clearing pass.
// Depends on llr_pkg, llr_if, llr_ram, llr_regs, llr_dp and llr_ctrl.
module looping_linear_resampler import llr_pkg::*; #(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  llr_in_if.sink                in_ch,
  llr_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  llr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  llr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  llr_dp #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .st               (st),
    .action           (in_ch.action),
    .sample_address   (in_ch.sample_address),
    .sample_left      (in_ch.sample_left),
    .sample_right     (in_ch.sample_right),
    .seek_position    (in_ch.seek_position),
    .out_left         (out_ch.out_left),
    .out_right        (out_ch.out_right),
    .frame_valid      (out_ch.frame_valid),
    .track_ended      (out_ch.track_ended),
    .current_position (out_ch.current_position)
  );

endmodule
